/* sv/vdit_pkg.sv */
// Package for the vertex dedup index table: item types, table entry and constants.
package vdit_pkg;

  localparam int unsigned TABLE_ENTRIES_DEF = 4096;
  localparam int unsigned INDEX_LIMIT       = 4096;
  localparam int unsigned INDEX_W           = 12;
  localparam int unsigned COUNT_W           = 13;
  localparam int unsigned KEY_W             = 32;
  localparam int unsigned HASH_W            = 64;
  localparam int unsigned EPOCH_W           = 8;

  localparam logic [HASH_W-1:0]  HASH_GOLDEN  = 64'h0000_0000_9e37_79b9;
  localparam logic [KEY_W-1:0]   ABSENT_INDEX = 32'hFFFF_FFFF;
  localparam logic [EPOCH_W-1:0] EPOCH_FIRST  = 8'd1;
  localparam logic [EPOCH_W-1:0] EPOCH_LAST   = 8'hFF;
  localparam logic [EPOCH_W-1:0] EPOCH_CLEAR  = 8'd0;

  typedef struct packed {
    logic [KEY_W-1:0] position_index;
    logic [KEY_W-1:0] texcoord_index;
    logic [KEY_W-1:0] normal_index;
    logic             end_of_object;
  } vdit_in_t;

  typedef struct packed {
    logic [INDEX_W-1:0] compact_index;
    logic               is_new;
    logic               has_texcoord;
    logic               has_normal;
    logic               table_full;
  } vdit_out_t;

  typedef struct packed {
    logic [EPOCH_W-1:0] epoch;
    logic [KEY_W-1:0]   position_key;
    logic [KEY_W-1:0]   texcoord_key;
    logic [KEY_W-1:0]   normal_key;
    logic [INDEX_W-1:0] assigned_index;
  } vdit_entry_t;

endpackage

/* sv/vertex_dedup_index_table_core.sv */
// Vertex dedup index table: hash, probe and insert of face-corner index triples.
//
//  channel | ports                    | handshake
//  --------+--------------------------+----------------------------------------
//  input   | start, busy, in_data     | item taken at edge with start & !busy
//  result  | out_valid, out_data      | one-cycle strobe, one result per item
//
// An item is hashed by one shared 64-bit mix step, applied to each of its three
// indices in turn. When TABLE_ENTRIES is not a power of two, folds then bring
// the hash below 2^32, and quotient and remainder steps on the shared multiplier
// and a fix step take the remainder. Then each probe reads the table memory
// (one read and one write port) and compares, and the core returns to idle.
// Reset runs a clearing pass over every table slot with busy high; the same
// pass runs after every 255th end-of-object (epoch tag wrap). Results cannot
// be stalled; busy alone holds off new items.
module vertex_dedup_index_table_core
  import vdit_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  vdit_in_t  in_data,
  output logic      out_valid,
  output vdit_out_t out_data
);

  localparam int unsigned SLOT_W = $clog2(TABLE_ENTRIES);
  localparam bit IS_POW2 = (TABLE_ENTRIES == (1 << SLOT_W));
  localparam int unsigned CAP_INT =
    (TABLE_ENTRIES < INDEX_LIMIT) ? TABLE_ENTRIES : INDEX_LIMIT;
  localparam logic [COUNT_W-1:0]  CAPACITY  = COUNT_W'(CAP_INT);
  localparam logic [SLOT_W-1:0]   SLOT_LAST = SLOT_W'(TABLE_ENTRIES - 1);
  localparam logic [SLOT_W:0]     MOD_N     = (SLOT_W + 1)'(TABLE_ENTRIES);
  localparam int unsigned HALF_W   = HASH_W / 2;
  localparam int unsigned MUL_W    = HALF_W + 1;
  localparam int unsigned RECIP_SH = HALF_W + SLOT_W;
  localparam logic [HASH_W-1:0]   FOLD_BASE = 64'h0000_0001_0000_0000;
  // 2^32 mod N folds the upper half onto the lower one
  localparam logic [MUL_W-1:0]    FOLD_R    = MUL_W'(FOLD_BASE % TABLE_ENTRIES);
  localparam logic [MUL_W-1:0]    RECIP     =
    MUL_W'((64'd1 << RECIP_SH) / TABLE_ENTRIES);
  localparam logic [MUL_W-1:0]    DIV_N     = MUL_W'(TABLE_ENTRIES);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_FOLD,
    S_QUOT,
    S_REM,
    S_FIX,
    S_PROBE_RD,
    S_PROBE_CMP
  } state_t;

  state_t             state_r, state_nxt;
  vdit_in_t           in_r, in_nxt;
  logic [HASH_W-1:0]  h_r, h_nxt;
  logic [1:0]         step_r, step_nxt;
  logic [HALF_W-1:0]  q_r, q_nxt;
  logic [SLOT_W-1:0]  slot_r, slot_nxt;
  logic [SLOT_W-1:0]  probes_r, probes_nxt;
  logic [SLOT_W-1:0]  clr_cnt_r, clr_cnt_nxt;
  logic [COUNT_W-1:0] next_free_r, next_free_nxt;
  logic [EPOCH_W-1:0] epoch_r, epoch_nxt;
  vdit_out_t          out_r, out_nxt;
  logic               out_valid_r, out_valid_nxt;

  vdit_entry_t        mem [TABLE_ENTRIES];
  vdit_entry_t        mem_rd_r;
  logic               mem_we;
  logic [SLOT_W-1:0]  mem_waddr;
  vdit_entry_t        mem_wdata;

  logic [HASH_W-1:0]  mix_val;
  logic [HASH_W-1:0]  mix_out;
  logic [HALF_W-1:0]  mul_a;
  logic [MUL_W-1:0]   mul_b;
  logic [HALF_W+MUL_W-1:0] mul_p;
  logic               slot_valid, slot_hit, do_insert;

  // shared hash-combine step
  always_comb begin
    unique case (step_r)
      2'd0:    mix_val = {32'b0, in_r.position_index};
      2'd1:    mix_val = {32'b0, in_r.texcoord_index};
      default: mix_val = {32'b0, in_r.normal_index};
    endcase
    mix_out = h_r ^ (mix_val + HASH_GOLDEN + (h_r << 6) + (h_r >> 2));
  end

  // shared multiplier: hash folding, reciprocal quotient, quotient times N
  always_comb begin
    unique case (state_r)
      S_QUOT: begin
        mul_a = h_r[HALF_W-1:0];
        mul_b = RECIP;
      end
      S_REM: begin
        mul_a = q_r;
        mul_b = DIV_N;
      end
      default: begin
        mul_a = h_r[HASH_W-1:HALF_W];
        mul_b = FOLD_R;
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  assign slot_valid = (mem_rd_r.epoch == epoch_r);
  assign slot_hit   = slot_valid
                    && (mem_rd_r.position_key == in_r.position_index)
                    && (mem_rd_r.texcoord_key == in_r.texcoord_index)
                    && (mem_rd_r.normal_key == in_r.normal_index);
  assign do_insert  = (state_r == S_PROBE_CMP) && !slot_valid && (next_free_r < CAPACITY);

  always_comb begin
    state_nxt     = state_r;
    in_nxt        = in_r;
    h_nxt         = h_r;
    step_nxt      = step_r;
    q_nxt         = q_r;
    slot_nxt      = slot_r;
    probes_nxt    = probes_r;
    clr_cnt_nxt   = clr_cnt_r;
    next_free_nxt = next_free_r;
    epoch_nxt     = epoch_r;
    out_nxt       = out_r;
    out_valid_nxt = 1'b0;

    unique case (state_r)
      S_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == SLOT_LAST) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          in_nxt    = in_data;
          h_nxt     = '0;
          step_nxt  = 2'd0;
          state_nxt = S_HASH;
        end
      end
      S_HASH: begin
        h_nxt    = mix_out;
        step_nxt = step_r + 1'b1;
        if (step_r == 2'd2) begin
          probes_nxt = '0;
          if (IS_POW2) begin
            slot_nxt  = mix_out[SLOT_W-1:0];
            state_nxt = S_PROBE_RD;
          end else begin
            state_nxt = S_FOLD;
          end
        end
      end
      S_FOLD: begin
        // at most four folds bring the hash below 2^32
        if (h_r[HASH_W-1:HALF_W] == '0) begin
          state_nxt = S_QUOT;
        end else begin
          h_nxt = mul_p[HASH_W-1:0] + {{HALF_W{1'b0}}, h_r[HALF_W-1:0]};
        end
      end
      S_QUOT: begin
        // quotient estimate is exact or one low
        q_nxt     = HALF_W'(mul_p >> RECIP_SH);
        state_nxt = S_REM;
      end
      S_REM: begin
        h_nxt     = {{HALF_W{1'b0}}, h_r[HALF_W-1:0] - mul_p[HALF_W-1:0]};
        state_nxt = S_FIX;
      end
      S_FIX: begin
        slot_nxt  = (h_r[SLOT_W:0] >= MOD_N) ? SLOT_W'(h_r[SLOT_W:0] - MOD_N)
                                             : h_r[SLOT_W-1:0];
        state_nxt = S_PROBE_RD;
      end
      S_PROBE_RD: begin
        state_nxt = S_PROBE_CMP;
      end
      S_PROBE_CMP: begin
        if (!slot_valid || slot_hit || probes_r == SLOT_LAST) begin
          out_nxt.has_texcoord = (in_r.texcoord_index != ABSENT_INDEX);
          out_nxt.has_normal   = (in_r.normal_index != ABSENT_INDEX);
          out_nxt.is_new       = do_insert;
          out_nxt.table_full   = !slot_hit && !do_insert;
          if (slot_hit) begin
            out_nxt.compact_index = mem_rd_r.assigned_index;
          end else if (do_insert) begin
            out_nxt.compact_index = next_free_r[INDEX_W-1:0];
          end else begin
            out_nxt.compact_index = '0;
          end
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
          if (do_insert) begin
            next_free_nxt = next_free_r + 1'b1;
          end
          if (in_r.end_of_object) begin
            // new epoch invalidates every slot; on wrap, sweep the tags
            next_free_nxt = '0;
            if (epoch_r == EPOCH_LAST) begin
              epoch_nxt   = EPOCH_FIRST;
              clr_cnt_nxt = '0;
              state_nxt   = S_CLEAR;
            end else begin
              epoch_nxt = epoch_r + 1'b1;
            end
          end
        end else begin
          slot_nxt   = (slot_r == SLOT_LAST) ? '0 : slot_r + 1'b1;
          probes_nxt = probes_r + 1'b1;
          state_nxt  = S_PROBE_RD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    mem_we    = (state_r == S_CLEAR) || do_insert;
    mem_waddr = (state_r == S_CLEAR) ? clr_cnt_r : slot_r;
    if (state_r == S_CLEAR) begin
      mem_wdata       = '0;
      mem_wdata.epoch = EPOCH_CLEAR;
    end else begin
      mem_wdata.epoch          = epoch_r;
      mem_wdata.position_key   = in_r.position_index;
      mem_wdata.texcoord_key   = in_r.texcoord_index;
      mem_wdata.normal_key     = in_r.normal_index;
      mem_wdata.assigned_index = next_free_r[INDEX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rd_r <= mem[slot_r];
  end

  always_ff @(posedge clk) begin
    in_r      <= in_nxt;
    h_r       <= h_nxt;
    step_r    <= step_nxt;
    q_r       <= q_nxt;
    slot_r    <= slot_nxt;
    probes_r  <= probes_nxt;
    out_r     <= out_nxt;
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      next_free_r <= '0;
      epoch_r     <= EPOCH_FIRST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      next_free_r <= next_free_nxt;
      epoch_r     <= epoch_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy && !out_valid))
    else $error("accepted item did not hold busy");

  a_new_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.is_new && out_data.table_full))
    else $error("result flagged both new and full");

  a_full_zero_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.table_full) |-> (out_data.compact_index == '0))
    else $error("full result carries nonzero index");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    next_free_r <= CAPACITY)
    else $error("index counter beyond capacity");

  a_new_index_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.is_new && !$past(in_r.end_of_object))
      |-> (next_free_r == COUNT_W'(out_data.compact_index) + 1'b1))
    else $error("new index does not match counter");

endmodule
